/* design/u8d_pkg.sv */
// Types and constants shared by the strict UTF-8 decoder modules.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

  // One input byte of the string.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_item_t;

  // One decoded result.
  typedef struct packed {
    logic [20:0] code_point;
    logic        last_of_string;
  } cp_item_t;

  // Work for the back end: rep_count replacement characters, then an
  // optional code point; last marks that the byte ended the string.
  typedef struct packed {
    logic [2:0]  rep_count;
    logic        cp_valid;
    logic [20:0] cp;
    logic        last;
  } cmd_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic not_empty;
    logic full;
  } fifo_status_t;

endpackage

/* design/u8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds result commands.
`timescale 1ns / 1ps

module u8d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  u8d_pkg::byte_item_t byte_data,
  input  logic                queue_full,
  output logic                push,
  output u8d_pkg::cmd_t       push_cmd
);

  logic [1:0]  pending_bytes;
  logic [1:0]  needed_bytes;
  logic [7:0]  lead_value;
  logic [20:0] partial_code;

  logic [1:0]  pending_bytes_next;
  logic [1:0]  needed_bytes_next;
  logic [7:0]  lead_value_next;
  logic [20:0] partial_code_next;

  logic [7:0]    b;
  logic [7:0]    lo;
  logic [7:0]    hi;
  logic          cont_ok;
  logic          start;
  logic          accept;
  logic [20:0]   acc;
  u8d_pkg::cmd_t cmd;

  assign b          = byte_data.data_byte;
  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign acc        = {partial_code[14:0], b[5:0]};

  // Continuation range, narrowed on the second byte after E0, ED, F0, F4.
  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (pending_bytes == 2'd1) begin
      case (lead_value)
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
    cont_ok = (b >= lo) && (b <= hi);
  end

  always_comb begin
    pending_bytes_next = pending_bytes;
    needed_bytes_next  = needed_bytes;
    lead_value_next    = lead_value;
    partial_code_next  = partial_code;
    cmd                = '0;
    start              = 1'b0;

    if (pending_bytes == 2'd0) begin
      start = 1'b1;
    end else if (cont_ok) begin
      if (pending_bytes == needed_bytes) begin
        cmd.cp_valid       = 1'b1;
        cmd.cp             = acc;
        pending_bytes_next = 2'd0;
        needed_bytes_next  = 2'd0;
        partial_code_next  = '0;
      end else begin
        pending_bytes_next = pending_bytes + 2'd1;
        partial_code_next  = acc;
      end
    end else begin
      // Broken sequence: replace every buffered byte, retry this one as a lead.
      cmd.rep_count      = {1'b0, pending_bytes};
      pending_bytes_next = 2'd0;
      needed_bytes_next  = 2'd0;
      partial_code_next  = '0;
      start              = 1'b1;
    end

    if (start) begin
      if (b < 8'h80) begin
        cmd.cp_valid = 1'b1;
        cmd.cp       = {13'd0, b};
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        needed_bytes_next  = 2'd1;
        partial_code_next  = {16'd0, b[4:0]};
        lead_value_next    = b;
        pending_bytes_next = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        needed_bytes_next  = 2'd2;
        partial_code_next  = {17'd0, b[3:0]};
        lead_value_next    = b;
        pending_bytes_next = 2'd1;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        needed_bytes_next  = 2'd3;
        partial_code_next  = {18'd0, b[2:0]};
        lead_value_next    = b;
        pending_bytes_next = 2'd1;
      end else begin
        cmd.rep_count = cmd.rep_count + 3'd1;
      end
    end

    // End of string: flush whatever is still open.
    if (byte_data.end_of_string) begin
      cmd.rep_count      = cmd.rep_count + {1'b0, pending_bytes_next};
      pending_bytes_next = 2'd0;
      needed_bytes_next  = 2'd0;
      partial_code_next  = '0;
    end
    cmd.last = byte_data.end_of_string;
  end

  assign push     = accept && ((cmd.rep_count != 3'd0) || cmd.cp_valid);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      needed_bytes  <= '0;
      lead_value    <= '0;
      partial_code  <= '0;
    end else if (accept) begin
      pending_bytes <= pending_bytes_next;
      needed_bytes  <= needed_bytes_next;
      lead_value    <= lead_value_next;
      partial_code  <= partial_code_next;
    end
  end

endmodule

/* design/u8d_fifo.sv */
// Command queue between the front and back ends.
`timescale 1ns / 1ps

module u8d_fifo #(
  parameter int unsigned Depth = u8d_pkg::FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  u8d_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output u8d_pkg::cmd_t          head,
  output u8d_pkg::fifo_status_t  status
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(Depth);

  u8d_pkg::cmd_t entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

/* design/u8d_back.sv */
// Back end: expands queued commands into one result per cycle while the receiver is ready.
`timescale 1ns / 1ps

module u8d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u8d_pkg::cmd_t         head,
  input  u8d_pkg::fifo_status_t status,
  output logic                  pop,
  output logic                  cp_valid,
  input  logic                  cp_ready,
  output u8d_pkg::cp_item_t     cp_data
);

  logic [2:0]         idx;
  logic [2:0]         total;
  logic               final_result;
  logic               load;
  logic               emit;
  u8d_pkg::cp_item_t  result;

  assign total        = head.rep_count + {2'd0, head.cp_valid};
  assign final_result = (idx + 3'd1) == total;
  assign load         = !cp_valid || cp_ready;
  assign emit         = load && status.not_empty;
  assign pop          = emit && final_result;

  always_comb begin
    result.code_point     = (idx < head.rep_count) ? u8d_pkg::REPLACEMENT_CP : head.cp;
    result.last_of_string = head.last && final_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      cp_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= final_result ? 3'd0 : idx + 3'd1;
      end
      if (load) begin
        cp_valid <= status.not_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_data <= result;
    end
  end

endmodule

/* design/utf8_strict_decoder.sv */
// Top level of the strict UTF-8 decoder: front end, command queue, back end.
//
//   channel   dir   handshake              payload
//   byte      in    byte_valid/byte_ready  byte_data (data_byte, end_of_string)
//   cp        out   cp_valid/cp_ready      cp_data (code_point, last_of_string)
//
// A byte is decoded in the cycle of its transfer and its results land in
// the command queue; while cp_ready allows, the back end sends one result
// per cycle from a registered output. Bytes giving at most one result
// stream at one per cycle while the queue has room; error bursts (up to
// four results per byte) drain at one result per cycle while cp_ready
// allows, and stall byte_ready only once the queue of FifoDepth commands
// is full. Reset clears the decode state, the queue and the output valid.
`timescale 1ns / 1ps

module utf8_strict_decoder #(
  parameter int unsigned FifoDepth = u8d_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  u8d_pkg::byte_item_t byte_data,
  output logic                cp_valid,
  input  logic                cp_ready,
  output u8d_pkg::cp_item_t   cp_data
);

  logic                  push;
  logic                  pop;
  u8d_pkg::cmd_t         push_cmd;
  u8d_pkg::cmd_t         head;
  u8d_pkg::fifo_status_t status;

  // Classify each byte and advance the sequence state.
  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .queue_full (status.full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Hold commands so either side can stall on its own.
  u8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  // Expand each command into its result transfers.
  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .status   (status),
    .pop      (pop),
    .cp_valid (cp_valid),
    .cp_ready (cp_ready),
    .cp_data  (cp_data)
  );

endmodule

/* test/utf8_strict_decoder_test.sv */
// Self-checking testbench for the strict UTF-8 decoder: directed, stall and random byte streams.
`timescale 1ns / 1ps

module utf8_strict_decoder_test;

  // Byte ranges of strict UTF-8.
  localparam logic [7:0] ASCII_MAX     = 8'h7F;
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hBF;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_SURR    = 8'hED;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  // Tighter second-byte bounds after the overlong and out-of-range leads.
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

  localparam int unsigned ITEM_TARGET = 170;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 16;
  // Longest correct silence is the receiver hold-off of HOLD_CYCLES; idle gaps
  // and four-result bursts stay far below this.
  localparam int unsigned STALL_LIMIT = 1000;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_ready;
  u8d_pkg::byte_item_t byte_data  = '0;
  logic                cp_valid;
  logic                cp_ready   = 1'b0;
  u8d_pkg::cp_item_t   cp_data;

  utf8_strict_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .cp_valid  (cp_valid),
    .cp_ready  (cp_ready),
    .cp_data   (cp_data)
  );

  always #5 clk = ~clk;

  // Decoder state as the predictor tracks it.
  logic [1:0]  open_bytes   = '0;  // bytes of the open sequence taken so far
  logic [1:0]  needed_conts = '0;  // continuation bytes the open sequence needs
  logic [7:0]  open_lead    = '0;
  logic [20:0] partial_cp   = '0;

  // Results of the byte being decoded, before they join the queue.
  u8d_pkg::cp_item_t byte_cps[4];
  int unsigned       byte_cp_count;

  u8d_pkg::cp_item_t awaited_cps[$];  // code points still to come, oldest first
  logic [7:0]  seq_bytes[$];       // byte sequence being built for the stream
  int unsigned sent_items   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Knobs for the idling of both sides.
  bit          tx_steady    = 1'b0;  // sender offers bytes back to back
  bit          rx_steady    = 1'b0;  // receiver takes every result at once
  int unsigned hold_request = 0;     // long receiver hold-off, picked up at negedge
  int unsigned rx_wait      = 0;

  function automatic void add_cp(logic [20:0] cp);
    byte_cps[byte_cp_count] = '{code_point: cp, last_of_string: 1'b0};
    byte_cp_count++;
  endfunction

  // Replace every buffered byte of the open sequence and close it.
  function automatic void flush_open();
    repeat (open_bytes) add_cp(u8d_pkg::REPLACEMENT_CP);
    open_bytes   = '0;
    needed_conts = '0;
    partial_cp   = '0;
  endfunction

  // Decode a byte at a sequence boundary: pass ASCII, open a sequence on a
  // valid lead, replace anything else.
  function automatic void start_lead(logic [7:0] b);
    if (b <= ASCII_MAX) begin
      add_cp({13'd0, b});
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      needed_conts = 2'd1;
      partial_cp   = {16'd0, b[4:0]};
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      needed_conts = 2'd2;
      partial_cp   = {17'd0, b[3:0]};
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      needed_conts = 2'd3;
      partial_cp   = {18'd0, b[2:0]};
    end else begin
      add_cp(u8d_pkg::REPLACEMENT_CP);
    end
    if (needed_conts != 0) begin
      open_lead  = b;
      open_bytes = 2'd1;
    end
  endfunction

  // Work out the code points that one accepted byte causes and queue them.
  function automatic void decode_byte(u8d_pkg::byte_item_t item);
    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int unsigned k;
    b             = item.data_byte;
    byte_cp_count = 0;
    if (open_bytes == 0) begin
      start_lead(b);
    end else begin
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (open_bytes == 2'd1) begin
        case (open_lead)
          LEAD3_MIN:  lo = E0_SECOND_MIN;
          LEAD3_SURR: hi = ED_SECOND_MAX;
          LEAD4_MIN:  lo = F0_SECOND_MIN;
          LEAD4_MAX:  hi = F4_SECOND_MAX;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        partial_cp = {partial_cp[14:0], b[5:0]};
        open_bytes = open_bytes + 2'd1;
        if (open_bytes == 0 || open_bytes > needed_conts) begin
          add_cp(partial_cp);
          open_bytes   = '0;
          needed_conts = '0;
          partial_cp   = '0;
        end
      end else begin
        // Broken sequence: replace what was buffered, retry the byte as a lead.
        flush_open();
        start_lead(b);
      end
    end
    if (item.end_of_string) begin
      flush_open();
      if (byte_cp_count != 0) byte_cps[byte_cp_count - 1].last_of_string = 1'b1;
    end
    for (k = 0; k < byte_cp_count; k++) awaited_cps.push_back(byte_cps[k]);
  endfunction

  // Check each code point transfer against the oldest expectation, then
  // predict from the byte transfer of the same edge. A result can never stem
  // from a byte taken at the same edge, so this order is safe.
  always @(posedge clk) begin
    u8d_pkg::cp_item_t want;
    if (!rst) begin
      if (cp_valid && cp_ready) begin
        if (awaited_cps.size() == 0) begin
          $error("unexpected result: code_point %h last_of_string %b",
                 cp_data.code_point, cp_data.last_of_string);
          mismatches++;
        end else begin
          want = awaited_cps.pop_front();
          if (cp_data.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, cp_data.code_point);
            mismatches++;
          end
          if (cp_data.last_of_string !== want.last_of_string) begin
            $error("last_of_string: expected %b, got %b",
                   want.last_of_string, cp_data.last_of_string);
            mismatches++;
          end
        end
        // Draw the stall before the next result.
        rx_wait = rx_steady ? 0 : $urandom_range(0, 10);
      end
      if (byte_valid && byte_ready) decode_byte(byte_data);
    end
  end

  // Receiver: hold ready low for the drawn stall, or for a requested hold-off.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      rx_wait      = hold_request;
      hold_request = 0;
    end
    if (rx_wait != 0) begin
      cp_ready <= 1'b0;
      rx_wait--;
    end else begin
      cp_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (cp_valid && cp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one byte after a random gap, or none when tx_steady, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_data  <= '{data_byte: b, end_of_string: eos};
    do @(posedge clk); while (!byte_ready);
    sent_items++;
  endtask

  // Drop valid and wait until every expected code point has arrived.
  task automatic wait_drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (awaited_cps.size() != 0) @(posedge clk);
  endtask

  // Fill seq_bytes with one well-formed sequence of len bytes, random content.
  function automatic void build_sequence(int unsigned len);
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int unsigned k;
    case (len)
      2:       lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
      3:       lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
      default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
    endcase
    lo = CONT_MIN;
    hi = CONT_MAX;
    case (lead)
      LEAD3_MIN:  lo = E0_SECOND_MIN;
      LEAD3_SURR: hi = ED_SECOND_MAX;
      LEAD4_MIN:  lo = F0_SECOND_MIN;
      LEAD4_MAX:  hi = F4_SECOND_MAX;
      default: ;
    endcase
    seq_bytes.push_back(lead);
    seq_bytes.push_back(8'($urandom_range(lo, hi)));
    for (k = 2; k < len; k++) seq_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
  endfunction

  // Both ends of the pass-through range.
  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(ASCII_MAX, 1'b0);
  endtask

  // Top of the 2-byte range, bottom of the 3-byte range, U+10FFFF.
  task automatic test_well_formed();
    send_byte(LEAD2_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b0);
    send_byte(LEAD3_MIN, 1'b0);
    send_byte(E0_SECOND_MIN, 1'b0);
    send_byte(CONT_MIN, 1'b0);
    send_byte(LEAD4_MAX, 1'b0);
    send_byte(F4_SECOND_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b0);
  endtask

  // Second byte just outside the restricted ranges: overlong, surrogate,
  // overlong 4-byte and beyond U+10FFFF. The failing byte is retried as a lead.
  task automatic test_second_byte_limits();
    send_byte(LEAD3_MIN, 1'b0);
    send_byte(E0_SECOND_MIN - 8'd1, 1'b0);
    send_byte(LEAD3_SURR, 1'b0);
    send_byte(ED_SECOND_MAX + 8'd1, 1'b0);
    send_byte(LEAD4_MIN, 1'b0);
    send_byte(F0_SECOND_MIN - 8'd1, 1'b0);
    send_byte(LEAD4_MAX, 1'b0);
    send_byte(F4_SECOND_MAX + 8'd1, 1'b0);
  endtask

  // Overlong 2-byte lead and a byte that can never start a sequence.
  task automatic test_invalid_leads();
    send_byte(LEAD2_MIN - 8'd1, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Three buffered bytes broken by a new lead that ends the string: three
  // replacements, then the lead itself flushed, last marked on the fourth.
  task automatic test_end_of_string();
    send_byte(LEAD4_MIN + 8'd1, 1'b0);
    send_byte(CONT_MIN, 1'b0);
    send_byte(CONT_MIN, 1'b0);
    send_byte(LEAD2_MIN, 1'b1);
  endtask

  // Hold the receiver off while bytes stream back to back, mostly error
  // bytes, so the command queue fills and byte_ready drops. Then pause the
  // sender until all results are out.
  task automatic test_backpressure();
    int unsigned k;
    hold_request = HOLD_CYCLES;
    tx_steady    = 1'b1;
    for (k = 0; k < 16; k++) begin
      if (k % 4 == 3) send_byte(8'($urandom_range(0, ASCII_MAX)), 1'b0);
      else            send_byte(8'($urandom_range(CONT_MIN, 8'hFF)), 1'b0);
    end
    tx_steady = 1'b0;
    wait_drain();
  endtask

  // Mostly well-formed sequences with random content; the rest are ASCII bytes,
  // truncated sequences followed by an arbitrary byte, and plain noise.
  task automatic test_random_stream();
    int unsigned pick;
    int unsigned cut;
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) tx_steady = ~tx_steady;
      if ($urandom_range(0, 19) == 0) rx_steady = ~rx_steady;
      pick = $urandom_range(0, 99);
      seq_bytes.delete();
      if (pick < 20) begin
        seq_bytes.push_back(8'($urandom_range(0, ASCII_MAX)));
      end else if (pick < 75) begin
        build_sequence(pick < 40 ? 2 : (pick < 60 ? 3 : 4));
      end else if (pick < 88) begin
        build_sequence($urandom_range(2, 4));
        cut = $urandom_range(1, seq_bytes.size() - 1);
        while (seq_bytes.size() > cut) void'(seq_bytes.pop_back());
        seq_bytes.push_back(8'($urandom));
      end else begin
        seq_bytes.push_back(8'($urandom));
      end
      foreach (seq_bytes[n]) send_byte(seq_bytes[n], $urandom_range(0, 11) == 0);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ascii();
    test_well_formed();
    test_second_byte_limits();
    test_invalid_leads();
    test_end_of_string();
    wait_drain();
    test_backpressure();
    test_random_stream();

    wait_drain();
    // Leave room for any stray result after the last expected one.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_cps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
